@@ hw/rtl/u16u8_pkg.sv @@
package u16u8_pkg;

    localparam int CODE_W    = 16;
    localparam int CAP_W     = 24;
    localparam int OUT_CNT_W = 24;
    localparam int BYTE_W    = 8;
    localparam int MAX_BYTES = 4;
    localparam int IDX_W     = $clog2(MAX_BYTES);
    localparam int CP_W      = 21;
    localparam int SURR_W    = 10;

    localparam logic [CAP_W-1:0] CAP_RESET = {CAP_W{1'b1}};

    // top six bits of a surrogate code unit
    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

    localparam logic [CP_W-1:0] SUPP_BASE = CP_W'(32'h10000);

    typedef enum logic [2:0] {
        ST_RUNNING      = 3'd0,
        ST_ILLEGAL      = 3'd1,
        ST_EXHAUSTED    = 3'd2,
        ST_NOT_CONSUMED = 3'd3,
        ST_SUCCESS      = 3'd4
    } status_t;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage

@@ hw/rtl/utf16_to_utf8_transcoder.sv @@
// channel   | handshake               | payload
// ----------+-------------------------+------------------------------------------------
// input     | in_valid / in_ready     | code_unit, source_last
// output    | out_valid / out_ready   | out_byte, byte_valid, run_last, status,
//           |                         | units_read, bytes_total
// config    | wr_en (no wait)         | wr_data (target_capacity)
//
// a code unit is decoded, checked and encoded in the cycle it is accepted; its
// bytes sit in a four-byte result buffer and leave one per cycle while out_ready is high
// one code unit per cycle while each character is one byte and out_ready stays high;
// a multi-byte character holds the input until its last byte leaves the byte-wide output
// a held high surrogate gives no result
// reset (rst_n, asynchronous) empties the buffer, clears counters and status and sets
// the capacity to all ones
module utf16_to_utf8_transcoder #(
    parameter int COUNT_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [u16u8_pkg::CAP_W-1:0]         wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [u16u8_pkg::CODE_W-1:0]        code_unit,
    input  logic                                source_last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [u16u8_pkg::BYTE_W-1:0]        out_byte,
    output logic                                byte_valid,
    output logic                                run_last,
    output u16u8_pkg::status_t                  status,
    output logic [u16u8_pkg::OUT_CNT_W-1:0]     units_read,
    output logic [u16u8_pkg::OUT_CNT_W-1:0]     bytes_total
);
    import u16u8_pkg::*;

    localparam int CMP_W = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 1;
    localparam int EXT_W = COUNT_BITS + OUT_CNT_W;

    // transcoder state
    logic [CAP_W-1:0]      cap_reg;
    logic                  pending_reg, pending_next;
    logic [SURR_W-1:0]     high_bits_reg, high_bits_next;
    logic [COUNT_BITS-1:0] written_reg, written_next;
    logic [COUNT_BITS-1:0] read_reg, read_next;
    logic                  halted_reg, halted_next;
    status_t               final_reg, final_next;

    // result buffer
    logic                  buf_valid_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      last_idx_reg, last_idx_next;
    logic                  has_byte_reg, has_byte_next;
    status_t               res_status_reg, res_status_next;
    logic [COUNT_BITS-1:0] wr_first_reg, wr_first_next;
    logic [COUNT_BITS-1:0] rd_old_reg;
    logic [COUNT_BITS-1:0] rd_new_reg;
    byte_t                 byte_reg [MAX_BYTES];
    byte_t                 byte_next [MAX_BYTES];

    logic in_fire, out_fire, at_end, load;

    logic                  is_high, is_low;
    logic                  try_char, do_halt, do_emit;
    status_t               halt_code;
    logic [CP_W-1:0]       cp;
    logic [1:0]            units;
    logic [2:0]            len;
    logic [IDX_W-1:0]      len_idx;

    assign is_high = (code_unit[CODE_W-1 -: 6] == HIGH_SURR_TAG);
    assign is_low  = (code_unit[CODE_W-1 -: 6] == LOW_SURR_TAG);

    always_comb
    begin
        pending_next    = pending_reg;
        high_bits_next  = high_bits_reg;
        written_next    = written_reg;
        read_next       = read_reg;
        halted_next     = halted_reg;
        final_next      = final_reg;
        load            = 1'b0;
        try_char        = 1'b0;
        do_halt         = 1'b0;
        do_emit         = 1'b0;
        halt_code       = ST_ILLEGAL;
        cp              = '0;
        units           = 2'd1;
        len             = 3'd1;
        len_idx         = '0;
        last_idx_next   = '0;
        has_byte_next   = 1'b0;
        res_status_next = final_reg;
        wr_first_next   = written_reg;
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            byte_next[i] = '0;
        end

        if (halted_reg)
        begin
            load = 1'b1;
        end
        else if (!pending_reg)
        begin
            if (CMP_W'(written_reg) >= CMP_W'(cap_reg))
            begin
                do_halt   = 1'b1;
                halt_code = ST_NOT_CONSUMED;
            end
            else if (is_low)
            begin
                do_halt = 1'b1;
            end
            else if (is_high)
            begin
                if (source_last)
                begin
                    do_halt = 1'b1;
                end
                else
                begin
                    pending_next   = 1'b1;
                    high_bits_next = code_unit[SURR_W-1:0];
                end
            end
            else
            begin
                try_char = 1'b1;
                cp       = CP_W'(code_unit);
            end
        end
        else
        begin
            if (!is_low)
            begin
                do_halt = 1'b1;
            end
            else
            begin
                try_char = 1'b1;
                units    = 2'd2;
                cp       = SUPP_BASE + CP_W'({high_bits_reg, code_unit[SURR_W-1:0]});
            end
        end

        if (try_char)
        begin
            if (cp < CP_W'(32'h80))
            begin
                len          = 3'd1;
                byte_next[0] = {1'b0, cp[6:0]};
            end
            else if (cp < CP_W'(32'h800))
            begin
                len          = 3'd2;
                byte_next[0] = {3'b110, cp[10:6]};
                byte_next[1] = {2'b10, cp[5:0]};
            end
            else if (cp < SUPP_BASE)
            begin
                len          = 3'd3;
                byte_next[0] = {4'b1110, cp[15:12]};
                byte_next[1] = {2'b10, cp[11:6]};
                byte_next[2] = {2'b10, cp[5:0]};
            end
            else
            begin
                len          = 3'd4;
                byte_next[0] = {5'b11110, cp[20:18]};
                byte_next[1] = {2'b10, cp[17:12]};
                byte_next[2] = {2'b10, cp[11:6]};
                byte_next[3] = {2'b10, cp[5:0]};
            end
            len_idx = IDX_W'(len - 3'd1);

            if (CMP_W'(written_reg) + CMP_W'(len) > CMP_W'(cap_reg))
            begin
                do_halt   = 1'b1;
                halt_code = ST_EXHAUSTED;
            end
            else
            begin
                do_emit = 1'b1;
            end
        end

        if (do_halt)
        begin
            load            = 1'b1;
            halted_next     = 1'b1;
            final_next      = halt_code;
            pending_next    = 1'b0;
            res_status_next = halt_code;
            for (int i = 0; i < MAX_BYTES; i++)
            begin
                byte_next[i] = '0;
            end
        end

        if (do_emit)
        begin
            load            = 1'b1;
            pending_next    = 1'b0;
            has_byte_next   = 1'b1;
            last_idx_next   = len_idx;
            wr_first_next   = written_reg + COUNT_BITS'(1);
            written_next    = written_reg + COUNT_BITS'(len);
            read_next       = read_reg + COUNT_BITS'(units);
            res_status_next = ST_RUNNING;
            if (source_last)
            begin
                halted_next     = 1'b1;
                final_next      = ST_SUCCESS;
                res_status_next = ST_SUCCESS;
            end
        end
    end

    assign at_end    = (idx_reg == last_idx_reg);
    assign in_ready  = !buf_valid_reg || (out_ready && at_end);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = buf_valid_reg;
    assign out_fire  = buf_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            pending_reg   <= 1'b0;
            high_bits_reg <= '0;
            written_reg   <= '0;
            read_reg      <= '0;
            halted_reg    <= 1'b0;
            final_reg     <= ST_RUNNING;
            buf_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                cap_reg <= wr_data;
            end
            if (in_fire)
            begin
                pending_reg   <= pending_next;
                high_bits_reg <= high_bits_next;
                written_reg   <= written_next;
                read_reg      <= read_next;
                halted_reg    <= halted_next;
                final_reg     <= final_next;
            end
            if (in_fire && load)
            begin
                buf_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (out_fire)
            begin
                if (at_end)
                begin
                    buf_valid_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
        end
    end

    // buffer payload, taken only with a new transaction
    always_ff @(posedge clk)
    begin
        if (in_fire && load)
        begin
            last_idx_reg   <= last_idx_next;
            has_byte_reg   <= has_byte_next;
            res_status_reg <= res_status_next;
            wr_first_reg   <= wr_first_next;
            rd_old_reg     <= read_reg;
            rd_new_reg     <= read_next;
            for (int i = 0; i < MAX_BYTES; i++)
            begin
                byte_reg[i] <= byte_next[i];
            end
        end
    end

    logic [COUNT_BITS-1:0] bytes_cnt;
    logic [COUNT_BITS-1:0] units_cnt;
    logic [EXT_W-1:0]      bytes_ext;
    logic [EXT_W-1:0]      units_ext;

    assign bytes_cnt   = wr_first_reg + COUNT_BITS'(idx_reg);
    assign units_cnt   = at_end ? rd_new_reg : rd_old_reg;
    assign bytes_ext   = {{OUT_CNT_W{1'b0}}, bytes_cnt};
    assign units_ext   = {{OUT_CNT_W{1'b0}}, units_cnt};

    assign out_byte    = byte_reg[idx_reg];
    assign byte_valid  = has_byte_reg;
    assign run_last    = at_end;
    assign status      = at_end ? res_status_reg : ST_RUNNING;
    assign bytes_total = bytes_ext[OUT_CNT_W-1:0];
    assign units_read  = units_ext[OUT_CNT_W-1:0];

    // input only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    // a transaction without a byte always reports a halt
    a_nobyte_halt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> run_last && status != ST_RUNNING && out_byte == '0)
        else $error("result without a byte carries no halting status");

    // halting status only on the last byte of a character
    a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_RUNNING |-> run_last)
        else $error("status reported before the last byte");

    // bytes of one character stay valid without a gap until the last one
    a_char_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_valid && byte_valid)
        else $error("character broken off before its last byte");

    // nothing is taken in while a multi-byte character is still draining
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> !in_ready)
        else $error("input accepted over an unfinished character");

endmodule

@@ tb/sv/utf16_to_utf8_transcoder_tb.sv @@
module utf16_to_utf8_transcoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u16u8_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        byte_t                data;
        logic                 valid;
        logic                 last;
        status_t              st;
        logic [OUT_CNT_W-1:0] units;
        logic [OUT_CNT_W-1:0] total;
    } utf8_out_t;

    class utf8_byte_board;
        logic [CAP_W-1:0]     capacity;
        logic                 high_held;
        logic [SURR_W-1:0]    high_bits;
        logic [OUT_CNT_W-1:0] bytes_done;
        logic [OUT_CNT_W-1:0] units_done;
        logic                 stopped;
        status_t              stop_status;
        utf8_out_t            due_bytes[$];
        int                   mismatches;

        function new();
            capacity    = CAP_RESET;
            high_held   = 1'b0;
            high_bits   = '0;
            bytes_done  = '0;
            units_done  = '0;
            stopped     = 1'b0;
            stop_status = ST_RUNNING;
            mismatches  = 0;
        endfunction

        function void push_result(byte_t data, logic valid, logic last, status_t st);
            utf8_out_t r;
            r.data  = data;
            r.valid = valid;
            r.last  = last;
            r.st    = st;
            r.units = units_done;
            r.total = bytes_done;
            due_bytes = {due_bytes, r};
        endfunction

        function void stop_run(status_t st);
            stopped     = 1'b1;
            stop_status = st;
            high_held   = 1'b0;
            push_result('0, 1'b0, 1'b1, st);
        endfunction

        // works out the bytes caused by one accepted code unit
        function void encode_unit(logic [CODE_W-1:0] cu, logic fin);
            logic [CP_W-1:0] cp;
            byte_t           seq[MAX_BYTES];
            int              len;
            int              units;
            int              step;
            logic            is_high;
            logic            is_low;
            status_t         st;

            is_high = (cu[CODE_W-1:SURR_W] == HIGH_SURR_TAG);
            is_low  = (cu[CODE_W-1:SURR_W] == LOW_SURR_TAG);
            if (stopped) begin
                push_result('0, 1'b0, 1'b1, stop_status);
                return;
            end
            if (!high_held) begin
                if (bytes_done >= capacity) begin
                    stop_run(ST_NOT_CONSUMED);
                    return;
                end
                if (is_low) begin
                    stop_run(ST_ILLEGAL);
                    return;
                end
                if (is_high) begin
                    if (fin) begin
                        stop_run(ST_ILLEGAL);
                    end
                    else begin
                        high_held = 1'b1;
                        high_bits = cu[SURR_W-1:0];
                    end
                    return;
                end
                cp    = CP_W'(cu);
                units = 1;
            end
            else begin
                if (!is_low) begin
                    stop_run(ST_ILLEGAL);
                    return;
                end
                cp        = SUPP_BASE + CP_W'({high_bits, cu[SURR_W-1:0]});
                units     = 2;
                high_held = 1'b0;
            end

            if (cp < CP_W'(32'h80)) begin
                len    = 1;
                seq[0] = cp[7:0];
            end
            else if (cp < CP_W'(32'h800)) begin
                len    = 2;
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            else if (cp < SUPP_BASE) begin
                len    = 3;
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            else begin
                len    = 4;
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end

            // whole character must fit before any of it is written
            if (longint'(bytes_done) + len > longint'(capacity)) begin
                stop_run(ST_EXHAUSTED);
                return;
            end

            for (step = 0; step < len; step++) begin
                bytes_done = bytes_done + 1'b1;
                st         = ST_RUNNING;
                if (step == len - 1) begin
                    units_done = units_done + OUT_CNT_W'(units);
                    if (fin) begin
                        stopped     = 1'b1;
                        stop_status = ST_SUCCESS;
                        st          = ST_SUCCESS;
                    end
                end
                push_result(seq[step], 1'b1, step == len - 1, st);
            end
        endfunction

        function void match_byte(utf8_out_t got);
            utf8_out_t want;
            if (due_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected output transaction: byte %h valid %b last %b",
                             $realtime, got.data, got.valid, got.last,
                             " status %0d units %0d total %0d",
                             got.st, got.units, got.total);
                return;
            end
            want = due_bytes.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: output mismatch", $realtime);
                    $display("  expected byte %h valid %b last %b status %0d",
                             want.data, want.valid, want.last, want.st,
                             " units %0d total %0d", want.units, want.total);
                    $display("  actual   byte %h valid %b last %b status %0d",
                             got.data, got.valid, got.last, got.st,
                             " units %0d total %0d", got.units, got.total);
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 wr_en       = 1'b0;
    logic [CAP_W-1:0]     wr_data     = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic [CODE_W-1:0]    code_unit   = '0;
    logic                 source_last = 1'b0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    byte_t                out_byte;
    logic                 byte_valid;
    logic                 run_last;
    status_t              status;
    logic [OUT_CNT_W-1:0] units_read;
    logic [OUT_CNT_W-1:0] bytes_total;

    logic                 calm        = 1'b0;
    int                   idle_cycles = 0;
    utf8_byte_board       board       = new();

    logic [CODE_W-1:0] warmup_units [19] = '{
        16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD7FF, 16'hE000,
        16'hFFFF, 16'h0041, 16'h00E9, 16'h20AC, 16'hFFFD,
        16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF, 16'hD83D, 16'hDE00, 16'h5555
    };

    utf16_to_utf8_transcoder #(
        .COUNT_BITS (24)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_data     (wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .code_unit   (code_unit),
        .source_last (source_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .run_last    (run_last),
        .status      (status),
        .units_read  (units_read),
        .bytes_total (bytes_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // both channels sampled with pre-edge values
    always @(posedge clk)
    begin
        utf8_out_t seen;
        if (rst_n) begin
            if (in_valid && in_ready)
                board.encode_unit(code_unit, source_last);
            if (out_valid && out_ready) begin
                seen.data  = out_byte;
                seen.valid = byte_valid;
                seen.last  = run_last;
                seen.st    = status;
                seen.units = units_read;
                seen.total = bytes_total;
                board.match_byte(seen);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $realtime, idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            gap = pick_gap();
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    task automatic send_unit(input logic [CODE_W-1:0] cu, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        code_unit   <= cu;
        source_last <= fin;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_pair(input logic fin);
        send_unit(CODE_W'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
        send_unit(CODE_W'($urandom_range(16'hDC00, 16'hDFFF)), fin);
    endtask

    // one well-formed character of random length
    task automatic send_char(input logic fin);
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 30)
            send_unit(CODE_W'($urandom_range(16'h0000, 16'h007F)), fin);
        else if (kind < 50)
            send_unit(CODE_W'($urandom_range(16'h0080, 16'h07FF)), fin);
        else if (kind < 62)
            send_unit(CODE_W'($urandom_range(16'h0800, 16'hD7FF)), fin);
        else if (kind < 75)
            send_unit(CODE_W'($urandom_range(16'hE000, 16'hFFFF)), fin);
        else
            send_pair(fin);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.due_bytes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        wr_en   <= 1'b1;
        wr_data <= value;
        @(posedge clk);
        wr_en         <= 1'b0;
        board.capacity = value;
    endtask

    task automatic send_noise(input int count);
        repeat (count)
            send_unit(CODE_W'($urandom), 1'($urandom));
    endtask

    initial
    begin
        int ending;
        int spare;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_capacity(CAP_RESET);
        calm = 1'b1;
        foreach (warmup_units[i])
            send_unit(warmup_units[i], 1'b0);
        calm = 1'b0;

        repeat (110)
            send_char(1'b0);

        // sender holds off until the output side has caught up
        drain_results();

        write_capacity(CAP_W'(32'h800000));
        repeat (90)
            send_char(1'b0);
        calm = 1'b1;
        repeat (60)
            send_char(1'b0);
        calm = 1'b0;

        write_capacity(board.bytes_done + CAP_W'(4000));
        repeat (80)
            send_char(1'b0);

        // one way of ending the run, chosen per seed
        ending = $urandom_range(0, 5);
        case (ending)
            0: send_char(1'b1);
            1: send_unit(CODE_W'($urandom_range(16'hDC00, 16'hDFFF)), 1'($urandom));
            2: begin
                send_unit(CODE_W'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
                if ($urandom_range(0, 1))
                    send_unit(CODE_W'($urandom_range(16'hD800, 16'hDBFF)), 1'($urandom));
                else
                    send_unit(CODE_W'($urandom_range(16'h0000, 16'hD7FF)), 1'($urandom));
            end
            3: send_unit(CODE_W'($urandom_range(16'hD800, 16'hDBFF)), 1'b1);
            4: begin
                // zero room gives not-consumed, some room too little for a pair
                spare = $urandom_range(0, 3);
                write_capacity(board.bytes_done + CAP_W'(spare));
                send_pair(1'b0);
            end
            default: begin
                // exact fit, then nothing left for the next character
                write_capacity(board.bytes_done + CAP_W'(4));
                send_pair(1'b0);
                send_char(1'b0);
            end
        endcase

        send_unit(16'hFFFF, 1'b1);
        send_unit(16'h0000, 1'b1);
        send_noise(25);
        write_capacity('0);
        send_noise(10);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/u16u8_pkg.sv
hw/rtl/utf16_to_utf8_transcoder.sv
tb/sv/utf16_to_utf8_transcoder_tb.sv
